FILE: src/svw_pkg.sv
// shared types, constants and the point distance test of the segment vertex welder
`default_nettype none

package svw_pkg;

   localparam int VERTEX_DEPTH = 256;
   localparam int COORD_WIDTH  = 24;
   localparam int IDX_W        = $clog2(VERTEX_DEPTH);
   localparam int CNT_W        = $clog2(VERTEX_DEPTH + 1);
   localparam int ONE_RAW      = 256;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QFILL_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_KEPT       = 2'd0,
      ST_DEGENERATE = 2'd1,
      ST_SAME       = 2'd2,
      ST_FULL       = 2'd3
   } status_type;

   typedef struct packed {
      logic                          first_of_mesh;
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] start_z;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] end_y;
      logic signed [COORD_WIDTH-1:0] end_z;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [7:0] index_start;
      logic [7:0] index_end;
      logic [8:0] vertex_total;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x;
      logic signed [COORD_WIDTH-1:0] y;
      logic signed [COORD_WIDTH-1:0] z;
   } vertex_type;

   // one classified segment waiting for the back end
   typedef struct packed {
      logic       first_of_mesh;
      logic       degenerate;
      vertex_type pt_a;
      vertex_type pt_b;
   } job_type;

   // squared distance under 1.0, exact
   function automatic logic is_close(vertex_type p, vertex_type q);
      logic signed [COORD_WIDTH:0] d [3];
      logic        [COORD_WIDTH:0] m;
      logic        [15:0]          sq;
      logic        [17:0]          sum;
      logic                        near;
      d[0] = (COORD_WIDTH+1)'(p.x) - (COORD_WIDTH+1)'(q.x);
      d[1] = (COORD_WIDTH+1)'(p.y) - (COORD_WIDTH+1)'(q.y);
      d[2] = (COORD_WIDTH+1)'(p.z) - (COORD_WIDTH+1)'(q.z);
      near = 1'b1;
      sum  = '0;
      for (int k = 0; k < 3; k++) begin
         m = d[k][COORD_WIDTH] ? -d[k] : d[k];
         if (m >= (COORD_WIDTH+1)'(ONE_RAW)) begin
            near = 1'b0;
         end
         sq  = {8'd0, m[7:0]} * {8'd0, m[7:0]};
         sum = sum + 18'(sq);
      end
      return near && (sum[17:16] == 2'b00);
   endfunction

endpackage

`default_nettype wire

FILE: src/svw_ram.sv
// generic single write port RAM with registered read
`default_nettype none

module svw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: src/svw_front.sv
// front end: takes segments and flags degenerate ones
`default_nettype none

module svw_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire svw_pkg::req_type req_data,
   output logic                  job_valid,
   input  wire logic             job_stall,
   output svw_pkg::job_type      job_data
);

   logic             valid_ff, valid_in;
   svw_pkg::job_type job_ff, job_in;
   svw_pkg::vertex_type pa, pb;

   assign req_stall = valid_ff && job_stall;
   assign job_valid = valid_ff;
   assign job_data  = job_ff;

   always_comb begin
      pa = '{x: req_data.start_x, y: req_data.start_y, z: req_data.start_z};
      pb = '{x: req_data.end_x, y: req_data.end_y, z: req_data.end_z};
      valid_in = valid_ff && job_stall;
      job_in   = job_ff;
      if (req_valid && !req_stall) begin
         valid_in             = 1'b1;
         job_in.first_of_mesh = req_data.first_of_mesh;
         job_in.degenerate    = svw_pkg::is_close(pa, pb);
         job_in.pt_a          = pa;
         job_in.pt_b          = pb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      job_ff <= job_in;
   end

endmodule

`default_nettype wire

FILE: src/svw_queue.sv
// short item queue between front and back end
`default_nettype none

module svw_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire svw_pkg::job_type in_data,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output svw_pkg::job_type      out_data
);

   svw_pkg::job_type                 entry_ff [svw_pkg::QUEUE_DEPTH];
   logic [svw_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [svw_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [svw_pkg::QFILL_W-1:0]      fill_ff, fill_in;
   logic                             push, pop;

   assign in_stall  = (fill_ff == svw_pkg::QFILL_W'(svw_pkg::QUEUE_DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && !in_stall;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

FILE: src/svw_back.sv
// back end: scans the vertex table, appends new vertices and registers the result
`default_nettype none

module svw_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             job_valid,
   output logic                  job_stall,
   input  wire svw_pkg::job_type job_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output svw_pkg::rsp_type      rsp_data
);

   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_SCAN    = 5'b00010,
      S_DECIDE  = 5'b00100,
      S_WRITE_B = 5'b01000,
      S_FINISH  = 5'b10000
   } back_state_type;

   localparam int VW = $bits(svw_pkg::vertex_type);

   back_state_type                state_ff, state_in;
   svw_pkg::job_type              job_ff, job_in;
   logic [svw_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [svw_pkg::CNT_W-1:0]     issue_ff, issue_in;
   logic                          chk_valid_ff, chk_valid_in;
   logic [svw_pkg::IDX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                          found_a_ff, found_a_in;
   logic                          found_b_ff, found_b_in;
   logic [svw_pkg::IDX_W-1:0]     idx_a_ff, idx_a_in;
   logic [svw_pkg::IDX_W-1:0]     idx_b_ff, idx_b_in;
   svw_pkg::status_type           status_ff, status_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   svw_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   logic                          wr_en;
   logic [svw_pkg::IDX_W-1:0]     wr_addr;
   svw_pkg::vertex_type           wr_data;
   logic [VW-1:0]                 rd_raw;
   svw_pkg::vertex_type           rd_vertex;
   logic                          hit_a, hit_b;
   logic [svw_pkg::CNT_W:0]       need_total;

   svw_ram #(
      .WIDTH (VW),
      .DEPTH (svw_pkg::VERTEX_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (issue_ff[svw_pkg::IDX_W-1:0]),
      .rd_data (rd_raw)
   );

   assign job_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rd_vertex = svw_pkg::vertex_type'(rd_raw);
   assign hit_a     = svw_pkg::is_close(job_ff.pt_a, rd_vertex);
   assign hit_b     = svw_pkg::is_close(job_ff.pt_b, rd_vertex);
   assign need_total = (svw_pkg::CNT_W+1)'(count_ff)
                     + (svw_pkg::CNT_W+1)'(!found_a_ff)
                     + (svw_pkg::CNT_W+1)'(!found_b_ff);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      found_a_in   = found_a_ff;
      found_b_in   = found_b_ff;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[svw_pkg::IDX_W-1:0];
      wr_data      = job_ff.pt_a;

      // first stored match wins for each end
      if (chk_valid_ff) begin
         if (hit_a && !found_a_ff) begin
            found_a_in = 1'b1;
            idx_a_in   = chk_idx_ff;
         end
         if (hit_b && !found_b_ff) begin
            found_b_in = 1'b1;
            idx_b_in   = chk_idx_ff;
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_in     = job_data;
               issue_in   = '0;
               found_a_in = 1'b0;
               found_b_in = 1'b0;
               idx_a_in   = '0;
               idx_b_in   = '0;
               if (job_data.first_of_mesh) begin
                  count_in = '0;
               end
               if (job_data.degenerate) begin
                  status_in = svw_pkg::ST_DEGENERATE;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff < count_ff) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_ff[svw_pkg::IDX_W-1:0];
               issue_in     = issue_ff + 1'b1;
            end else if (!chk_valid_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (found_a_ff && found_b_ff && idx_a_ff == idx_b_ff) begin
               status_in = svw_pkg::ST_SAME;
               idx_a_in  = '0;
               idx_b_in  = '0;
               state_in  = S_FINISH;
            end else if (need_total > (svw_pkg::CNT_W+1)'(svw_pkg::VERTEX_DEPTH)) begin
               status_in = svw_pkg::ST_FULL;
               idx_a_in  = '0;
               idx_b_in  = '0;
               state_in  = S_FINISH;
            end else begin
               status_in = svw_pkg::ST_KEPT;
               if (!found_a_ff) begin
                  wr_en    = 1'b1;
                  idx_a_in = count_ff[svw_pkg::IDX_W-1:0];
                  count_in = count_ff + 1'b1;
               end
               state_in = S_WRITE_B;
            end
         end
         S_WRITE_B: begin
            wr_data = job_ff.pt_b;
            if (!found_b_ff) begin
               wr_en    = 1'b1;
               idx_b_in = count_ff[svw_pkg::IDX_W-1:0];
               count_in = count_ff + 1'b1;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = status_ff;
               rsp_data_in.index_start  = 8'(idx_a_ff);
               rsp_data_in.index_end    = 8'(idx_b_ff);
               rsp_data_in.vertex_total = 9'(count_ff);
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff      <= job_in;
      issue_ff    <= issue_in;
      chk_idx_ff  <= chk_idx_in;
      found_a_ff  <= found_a_in;
      found_b_ff  <= found_b_in;
      idx_a_ff    <= idx_a_in;
      idx_b_ff    <= idx_b_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

FILE: src/segment_vertex_welder.sv
// top level of the segment vertex welder
// Each item is one 3D segment whose two endpoints are welded into a vertex
// table of VERTEX_DEPTH entries held in a single RAM. The front end registers
// the item and flags segments shorter than 1.0; a two-entry queue sits between
// it and the back end, so new items are taken while a segment is being welded
// or while its result waits in the output register. The back end reads one
// stored vertex per cycle on the RAM read port and tests it against both
// endpoints at once, so an item occupies the back end for longer the more
// vertices are stored (up to VERTEX_DEPTH); a degenerate segment skips the
// scan. New vertices are written start before end through the single write
// port. A set first_of_mesh empties the table at once by clearing the vertex
// count. One result item comes out for every segment, in order.
`default_nettype none

module segment_vertex_welder (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire svw_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output svw_pkg::rsp_type      rsp_data
);

   logic             fq_valid, fq_stall;
   svw_pkg::job_type fq_data;
   logic             qb_valid, qb_stall;
   svw_pkg::job_type qb_data;

   svw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (fq_valid),
      .job_stall (fq_stall),
      .job_data  (fq_data)
   );

   svw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_stall  (fq_stall),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_stall (qb_stall),
      .out_data  (qb_data)
   );

   svw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (qb_valid),
      .job_stall (qb_stall),
      .job_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: verif/weld_checker.sv
// checker for the segment vertex welder: predicts each weld result and compares it with the block
module weld_checker
   import svw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      int x;
      int y;
      int z;
   } point_type;

   point_type welded [VERTEX_DEPTH];
   int        welded_count;
   rsp_type   expected_welds [$];

   function automatic bit within_unit(point_type p, point_type q);
      int d [3];
      int sum;
      d[0] = p.x - q.x;
      d[1] = p.y - q.y;
      d[2] = p.z - q.z;
      sum  = 0;
      for (int k = 0; k < 3; k++) begin
         if (d[k] < 0) begin
            d[k] = -d[k];
         end
         if (d[k] >= ONE_RAW) begin
            return 1'b0;
         end
         sum += d[k] * d[k];
      end
      return sum < ONE_RAW * ONE_RAW;
   endfunction

   // lowest stored vertex within one unit, -1 if none
   function automatic int find_welded(point_type p);
      for (int i = 0; i < welded_count; i++) begin
         if (within_unit(p, welded[i])) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic rsp_type weld_segment(req_type r);
      point_type a;
      point_type b;
      int        ia;
      int        ib;
      int        need;
      rsp_type   res;
      res = '0;
      if (r.first_of_mesh) begin
         welded_count = 0;
      end
      a.x = int'(r.start_x);
      a.y = int'(r.start_y);
      a.z = int'(r.start_z);
      b.x = int'(r.end_x);
      b.y = int'(r.end_y);
      b.z = int'(r.end_z);
      if (within_unit(a, b)) begin
         res.status = ST_DEGENERATE;
      end else begin
         ia = find_welded(a);
         ib = find_welded(b);
         if (ia >= 0 && ia == ib) begin
            res.status = ST_SAME;
         end else begin
            need = 0;
            if (ia < 0) begin
               need++;
            end
            if (ib < 0) begin
               need++;
            end
            if (welded_count + need > VERTEX_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // new vertices go in start before end
               if (ia < 0) begin
                  ia = welded_count;
                  welded[ia] = a;
                  welded_count++;
               end
               if (ib < 0) begin
                  ib = welded_count;
                  welded[ib] = b;
                  welded_count++;
               end
               res.status      = ST_KEPT;
               res.index_start = 8'(ia);
               res.index_end   = 8'(ib);
            end
         end
      end
      res.vertex_total = 9'(welded_count);
      return res;
   endfunction

   function automatic void flag_field(string field, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_welds.delete();
         welded_count = 0;
         fail_count   = 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_welds.size() == 0) begin
               $display("%0t: no item pending, expected nothing got status %0d total %0d",
                        $time, rsp_data.status, rsp_data.vertex_total);
               fail_count++;
            end else begin
               want = expected_welds.pop_front();
               flag_field("status", int'(want.status), int'(rsp_data.status));
               flag_field("index_start", int'(want.index_start), int'(rsp_data.index_start));
               flag_field("index_end", int'(want.index_end), int'(rsp_data.index_end));
               flag_field("vertex_total", int'(want.vertex_total),
                          int'(rsp_data.vertex_total));
            end
         end
         if (req_valid && !req_stall) begin
            expected_welds.push_back(weld_segment(req_data));
         end
         outstanding <= expected_welds.size();
      end
   end

endmodule

FILE: verif/segment_vertex_welder_tb.sv
// testbench top for the segment vertex welder: segment stimulus, result stalls and verdict
module segment_vertex_welder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import svw_pkg::*;

   localparam int RANDOM_SEGMENTS = 800;
   localparam int COORD_MAX       = 8388607;
   localparam int COORD_MIN       = -8388608;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef enum {
      SEG_FRESH,
      SEG_REUSE_START,
      SEG_REUSE_END,
      SEG_REUSE_BOTH,
      SEG_SAME,
      SEG_SHORT
   } seg_kind_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    quiet     = 1'b0;
   int      fail_count;
   int      outstanding;
   int      stall_left;

   vertex_type mesh_points [$];

   always #5 clock = ~clock;

   segment_vertex_welder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   weld_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // result side: after each accepted item hold off for a random number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            stall_left = quiet ? 0 : int'($urandom_range(0, 11));
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #15_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic vertex_type pt(int x, int y, int z);
      vertex_type v;
      v.x = COORD_WIDTH'(x);
      v.y = COORD_WIDTH'(y);
      v.z = COORD_WIDTH'(z);
      return v;
   endfunction

   function automatic int wobble(int reach);
      return int'($urandom_range(0, 2 * reach)) - reach;
   endfunction

   function automatic coord_type any_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? COORD_WIDTH'(COORD_MAX) : COORD_WIDTH'(COORD_MIN);
         1: return COORD_WIDTH'(wobble(2048));
         default: return COORD_WIDTH'($urandom());
      endcase
   endfunction

   function automatic vertex_type fresh_point();
      vertex_type v;
      v.x = any_coord();
      v.y = any_coord();
      v.z = any_coord();
      return v;
   endfunction

   function automatic vertex_type shifted(vertex_type p, int dx, int dy, int dz);
      return pt(int'(p.x) + dx, int'(p.y) + dy, int'(p.z) + dz);
   endfunction

   function automatic vertex_type pool_point();
      if (mesh_points.size() == 0) begin
         return fresh_point();
      end
      return mesh_points[$urandom_range(0, mesh_points.size() - 1)];
   endfunction

   // a point around p, now and then right on either side of the one unit rim
   function automatic vertex_type near_point(vertex_type p);
      int ofs [3];
      int rot;
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 5))
            0:       ofs = '{255, 0, 0};
            1:       ofs = '{256, 0, 0};
            2:       ofs = '{181, 181, 0};
            3:       ofs = '{182, 181, 0};
            4:       ofs = '{147, 147, 148};
            default: ofs = '{148, 148, 148};
         endcase
         for (int k = 0; k < 3; k++) begin
            if ($urandom_range(0, 1)) begin
               ofs[k] = -ofs[k];
            end
         end
      end else begin
         for (int k = 0; k < 3; k++) begin
            ofs[k] = wobble(150);
         end
      end
      rot = $urandom_range(0, 2);
      return shifted(p, ofs[rot], ofs[(rot + 1) % 3], ofs[(rot + 2) % 3]);
   endfunction

   function automatic seg_kind_type pick_kind(bit long_mesh);
      int roll;
      roll = $urandom_range(0, 99);
      if (long_mesh) begin
         // mostly new vertices so the table runs full
         if (roll < 65) return SEG_FRESH;
         if (roll < 72) return SEG_REUSE_START;
         if (roll < 79) return SEG_REUSE_END;
         if (roll < 88) return SEG_REUSE_BOTH;
         if (roll < 94) return SEG_SAME;
         return SEG_SHORT;
      end
      if (roll < 25) return SEG_FRESH;
      if (roll < 38) return SEG_REUSE_START;
      if (roll < 50) return SEG_REUSE_END;
      if (roll < 65) return SEG_REUSE_BOTH;
      if (roll < 80) return SEG_SAME;
      return SEG_SHORT;
   endfunction

   // called at a clock edge; valid stays high when the next item follows at once
   task automatic send_segment(bit fom, vertex_type a, vertex_type b);
      int      gap;
      req_type item;
      gap = quiet ? 0 : int'($urandom_range(0, 11));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.first_of_mesh = fom;
      item.start_x       = a.x;
      item.start_y       = a.y;
      item.start_z       = a.z;
      item.end_x         = b.x;
      item.end_y         = b.y;
      item.end_z         = b.z;
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   initial begin
      int         sent;
      int         mesh_no;
      int         mesh_len;
      bit         long_mesh;
      vertex_type a;
      vertex_type b;
      vertex_type p;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_segment(1'b1, pt(0, 0, 0), pt(0, 0, 0));
      send_segment(1'b0, pt(COORD_MAX, COORD_MAX, COORD_MAX),
                   pt(COORD_MIN, COORD_MIN, COORD_MIN));
      send_segment(1'b0, pt(COORD_MAX, COORD_MAX, COORD_MAX),
                   pt(COORD_MAX, COORD_MAX, COORD_MAX - 256));
      // both ends inside the same stored vertex, far from each other
      send_segment(1'b0, pt(COORD_MAX - 200, COORD_MAX, COORD_MAX),
                   pt(COORD_MAX, COORD_MAX - 200, COORD_MAX));
      send_segment(1'b0, pt(COORD_MIN + 181, COORD_MIN + 181, COORD_MIN), pt(0, 0, 0));
      send_segment(1'b0, pt(COORD_MIN + 182, COORD_MIN + 181, COORD_MIN),
                   pt(5000, 5000, 5000));
      send_segment(1'b0, pt(1000, 0, 0), pt(1255, 0, 0));
      send_segment(1'b0, pt(1000, 0, 0), pt(1256, 0, 0));
      send_segment(1'b0, pt(-147, -147, -148), pt(148, 148, 148));
      send_segment(1'b0, pt(0, 0, -255), pt(COORD_MIN, COORD_MAX, 0));
      send_segment(1'b1, pt(0, 0, 0), pt(COORD_MAX, COORD_MIN, COORD_MAX));
      send_segment(1'b1, pt(0, 0, 0), pt(COORD_MAX, COORD_MIN, COORD_MAX));
      send_segment(1'b0, pt(0, 0, 0), pt(COORD_MAX, COORD_MIN, COORD_MAX));
      send_segment(1'b0, pt(COORD_MAX, COORD_MIN, COORD_MAX), pt(0, 0, 0));
      send_segment(1'b0, pt(COORD_MIN, COORD_MIN, COORD_MIN),
                   pt(COORD_MIN + 100, COORD_MIN + 100, COORD_MIN + 100));
      send_segment(1'b0, pt('h555555, 'hAAAAAA, 'h555555), pt('hAAAAAA, 'h555555, 'hAAAAAA));
      send_segment(1'b0, pt(-1, -1, -1), pt(1, 1, 1));
      wait_idle();

      sent    = 0;
      mesh_no = 0;
      while (sent < RANDOM_SEGMENTS) begin
         long_mesh = (mesh_no % 4 == 0);
         mesh_len  = long_mesh ? int'($urandom_range(160, 220)) : int'($urandom_range(3, 40));
         quiet <= ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) begin
            wait_idle();
         end
         mesh_points.delete();
         for (int i = 0; i < mesh_len && sent < RANDOM_SEGMENTS; i++) begin
            case (pick_kind(long_mesh))
               SEG_FRESH: begin
                  a = fresh_point();
                  b = fresh_point();
               end
               SEG_REUSE_START: begin
                  a = near_point(pool_point());
                  b = fresh_point();
               end
               SEG_REUSE_END: begin
                  a = fresh_point();
                  b = near_point(pool_point());
               end
               SEG_REUSE_BOTH: begin
                  a = near_point(pool_point());
                  b = near_point(pool_point());
               end
               SEG_SAME: begin
                  p = pool_point();
                  a = shifted(p, -140, wobble(20), wobble(20));
                  b = shifted(p, 140, wobble(20), wobble(20));
               end
               default: begin
                  a = $urandom_range(0, 1) ? pool_point() : fresh_point();
                  b = near_point(a);
               end
            endcase
            send_segment(i == 0, a, b);
            mesh_points.push_back(a);
            mesh_points.push_back(b);
            sent++;
         end
         mesh_no++;
      end

      wait_idle();
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
src/svw_pkg.sv
src/svw_ram.sv
src/svw_front.sv
src/svw_queue.sv
src/svw_back.sv
src/segment_vertex_welder.sv
verif/weld_checker.sv
verif/segment_vertex_welder_tb.sv
